// File: design/cfg_reachability_liveness_assert.svh
// Assertion macros for the control-flow analysis block.
// Included by design/cfg_reachability_liveness.sv; relies on aclk and aresetn in scope.
`ifndef CFG_REACHABILITY_LIVENESS_ASSERT_SVH
`define CFG_REACHABILITY_LIVENESS_ASSERT_SVH

// Same-cycle implication.
`define CFGRL_ASSERT_NOW(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (conseq)) \
        else $error(msg);

// Next-cycle implication.
`define CFGRL_ASSERT_NEXT(lbl, cond, conseq, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// File: design/cfgrl_pkg.sv
// Shared types and codes for the control-flow reachability/liveness block.
// No dependencies.
`timescale 1ns / 1ps

package cfgrl_pkg;

    localparam int IN_DATA_W  = 88;  // src, dst, block, use, def, zero pad
    localparam int OUT_DATA_W = 72;  // block, reachable, live_in, live_out, zero pad

    localparam logic [1:0] REQ_EDGE = 2'd0;
    localparam logic [1:0] REQ_LOAD = 2'd1;
    localparam logic [1:0] REQ_RUN  = 2'd2;

    localparam logic [1:0] CFG_ENTRY = 2'd0;
    localparam logic [1:0] CFG_NBLK  = 2'd1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE_WR,
        S_RPICK,
        S_RUPD,
        S_LROW,
        S_LLAT,
        S_LSCAN,
        S_LUPD,
        S_ORD,
        S_OLAT,
        S_OVAL
    } state_t;

endpackage

// File: design/cfgrl_lowbit.sv
// Priority encoder: index of the lowest set bit of a vector.
// No package dependencies.
`timescale 1ns / 1ps

module cfgrl_lowbit #(
    parameter int W = 64
) (
    input  logic [W-1:0]         vec,
    output logic [$clog2(W)-1:0] idx,
    output logic                 found
);

    always_comb begin
        idx   = '0;
        found = 1'b0;
        for (int i = W - 1; i >= 0; i--) begin
            if (vec[i]) begin
                idx   = i[$clog2(W)-1:0];
                found = 1'b1;
            end
        end
    end

endmodule

// File: design/cfg_reachability_liveness.sv
// Control-flow graph reachability and liveness analysis, top level.
// Depends on cfgrl_pkg, cfgrl_lowbit and cfg_reachability_liveness_assert.svh.
//
// Usage: words on the s_ channel carry a request kind in s_tuser. Add-edge
// reads the successor row in S_IDLE and writes it back in S_EDGE_WR; load-block
// writes in S_IDLE; requests with an endpoint or block at or above num_blocks
// are dropped. A run walks reachability from entry_block (S_RPICK and S_RUPD per
// reachable block, the update waiting on the successor-row memory read), then
// iterates liveness passes over blocks n-1..0 until no set changes. Each block
// goes through S_LROW, S_LLAT, S_LSCAN (one successor at a time, bounded by the
// single live-in memory read port) and S_LUPD. Results then stream on m_ one
// per block, each through S_ORD and S_OLAT to S_OVAL, where it waits on m_tready;
// m_tlast marks the last block. A stalled receiver holds the word in the
// output register; no new request is taken until the run is fully delivered.
// Config writes (cfg_we) are taken at any edge but must only happen when idle.
// Reset idles the control state (num_blocks to 1) and clears the per-entry valid
// bits, so the graph and use/def masks read back as empty with no clearing pass.
`timescale 1ns / 1ps

module cfg_reachability_liveness
    import cfgrl_pkg::*;
#(
    parameter int MAX_BLOCKS = 64,
    parameter int MAX_VARS   = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // src_block, dst_block, block_id, use_vars, def_vars
    input  logic [1:0]            s_tuser,   // req_type
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // out_block, reachable, live_in, live_out
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_addr,
    input  logic [6:0]            cfg_wdata
);

    localparam int NB = (MAX_BLOCKS > 64) ? 64 : MAX_BLOCKS;
    localparam int BW = $clog2(NB);
    localparam int VW = MAX_VARS;

    // memories
    logic [NB-1:0]   succ_mem [NB];
    logic [2*VW-1:0] ud_mem   [NB];
    logic [VW-1:0]   li_mem   [NB];
    logic [VW-1:0]   lo_mem   [NB];

    logic [BW-1:0]   succ_raddr, succ_waddr, succ_raddr_reg;
    logic [NB-1:0]   succ_wdata, succ_rdata_reg, succ_q;
    logic            succ_we;
    logic [BW-1:0]   ud_raddr, ud_waddr, ud_raddr_reg;
    logic [2*VW-1:0] ud_wdata, ud_rdata_reg, ud_q;
    logic            ud_we;
    logic [BW-1:0]   li_raddr, lo_raddr, lv_waddr, li_raddr_reg, lo_raddr_reg;
    logic [VW-1:0]   li_wdata, lo_wdata, li_rdata_reg, lo_rdata_reg, li_q, lo_q;
    logic            lv_we;

    // control
    state_t        state_reg, state_next;
    logic [5:0]    entry_reg, entry_next;
    logic [6:0]    nblk_reg, nblk_next;
    logic [BW-1:0] src_reg, src_next, dst_reg, dst_next, blk_reg, blk_next;
    logic [NB-1:0] reach_reg, reach_next, pend_reg, pend_next, row_reg, row_next;
    logic [NB-1:0] sv_reg, sv_next, udv_reg, udv_next, lv_reg, lv_next;
    logic [VW-1:0] use_reg, use_next, def_reg, def_next;
    logic [VW-1:0] oin_reg, oin_next, oout_reg, oout_next, acc_reg, acc_next;
    logic          rpend_reg, rpend_next, chg_reg, chg_next;
    logic [5:0]    ob_reg, ob_next;
    logic          oreach_reg, oreach_next, olast_reg, olast_next;
    logic [VW-1:0] oli_reg, oli_next, olo_reg, olo_next;

    logic [6:0]    n_c, nm1_c, blk_inc_c;
    logic [NB-1:0] lim_c, fresh_c;
    logic [BW-1:0] pj_c, rj_c;
    logic          pfound_c, rfound_c;
    logic [5:0]    in_src, in_dst, in_bid;
    logic [63:0]   use_ext, def_ext, li_ext, lo_ext;
    logic [VW-1:0] nin_c;

    assign in_src = s_tdata[5:0];
    assign in_dst = s_tdata[11:6];
    assign in_bid = s_tdata[17:12];

    always_comb begin
        use_ext = '0;
        def_ext = '0;
        use_ext[31:0] = s_tdata[49:18];
        def_ext[31:0] = s_tdata[81:50];
    end

    assign n_c       = (nblk_reg > 7'(NB)) ? 7'(NB) : nblk_reg;
    assign nm1_c     = n_c - 7'd1;
    assign blk_inc_c = 7'(blk_reg) + 7'd1;

    always_comb begin
        for (int i = 0; i < NB; i++) begin
            lim_c[i] = (7'(i) < n_c);
        end
    end

    cfgrl_lowbit #(.W(NB)) u_pend_pick (.vec(pend_reg), .idx(pj_c), .found(pfound_c));
    cfgrl_lowbit #(.W(NB)) u_row_pick  (.vec(row_reg),  .idx(rj_c), .found(rfound_c));

    // entries never written since reset (or since liveness began for live sets) read as zero
    assign succ_q = sv_reg[succ_raddr_reg] ? succ_rdata_reg : '0;
    assign ud_q   = udv_reg[ud_raddr_reg] ? ud_rdata_reg : '0;
    assign li_q   = lv_reg[li_raddr_reg] ? li_rdata_reg : '0;
    assign lo_q   = lv_reg[lo_raddr_reg] ? lo_rdata_reg : '0;

    assign fresh_c = succ_q & lim_c & ~reach_reg;
    assign nin_c   = use_reg | (acc_reg & ~def_reg);

    always_ff @(posedge aclk) begin
        if (succ_we) begin
            succ_mem[succ_waddr] <= succ_wdata;
        end
        succ_rdata_reg <= succ_mem[succ_raddr];
        succ_raddr_reg <= succ_raddr;
    end

    always_ff @(posedge aclk) begin
        if (ud_we) begin
            ud_mem[ud_waddr] <= ud_wdata;
        end
        ud_rdata_reg <= ud_mem[ud_raddr];
        ud_raddr_reg <= ud_raddr;
    end

    always_ff @(posedge aclk) begin
        if (lv_we) begin
            li_mem[lv_waddr] <= li_wdata;
            lo_mem[lv_waddr] <= lo_wdata;
        end
        li_rdata_reg <= li_mem[li_raddr];
        lo_rdata_reg <= lo_mem[lo_raddr];
        li_raddr_reg <= li_raddr;
        lo_raddr_reg <= lo_raddr;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    case (s_tuser)
                        REQ_EDGE: begin
                            if ({1'b0, in_src} < n_c && {1'b0, in_dst} < n_c) begin
                                state_next = S_EDGE_WR;
                            end
                        end
                        REQ_RUN: begin
                            if (n_c != 7'd0) begin
                                state_next = S_RPICK;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_EDGE_WR: state_next = S_IDLE;
            S_RPICK:   state_next = pfound_c ? S_RUPD : S_LROW;
            S_RUPD:    state_next = S_RPICK;
            S_LROW:    state_next = S_LLAT;
            S_LLAT:    state_next = S_LSCAN;
            S_LSCAN:   state_next = rfound_c ? S_LSCAN : S_LUPD;
            S_LUPD: begin
                if (blk_reg != '0) begin
                    state_next = S_LROW;
                end else if (chg_reg || nin_c != oin_reg || acc_reg != oout_reg) begin
                    state_next = S_LROW;
                end else begin
                    state_next = S_ORD;
                end
            end
            S_ORD:  state_next = S_OLAT;
            S_OLAT: state_next = S_OVAL;
            S_OVAL: begin
                if (m_tready) begin
                    state_next = olast_reg ? S_IDLE : S_ORD;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        entry_next  = entry_reg;
        nblk_next   = nblk_reg;
        src_next    = src_reg;
        dst_next    = dst_reg;
        blk_next    = blk_reg;
        reach_next  = reach_reg;
        pend_next   = pend_reg;
        row_next    = row_reg;
        sv_next     = sv_reg;
        udv_next    = udv_reg;
        lv_next     = lv_reg;
        use_next    = use_reg;
        def_next    = def_reg;
        oin_next    = oin_reg;
        oout_next   = oout_reg;
        acc_next    = acc_reg;
        rpend_next  = rpend_reg;
        chg_next    = chg_reg;
        ob_next     = ob_reg;
        oreach_next = oreach_reg;
        olast_next  = olast_reg;
        oli_next    = oli_reg;
        olo_next    = olo_reg;

        succ_raddr = blk_reg;
        succ_waddr = src_reg;
        succ_wdata = '0;
        succ_we    = 1'b0;
        ud_raddr   = blk_reg;
        ud_waddr   = in_bid[BW-1:0];
        ud_wdata   = {def_ext[VW-1:0], use_ext[VW-1:0]};
        ud_we      = 1'b0;
        li_raddr   = blk_reg;
        lo_raddr   = blk_reg;
        lv_waddr   = blk_reg;
        li_wdata   = nin_c;
        lo_wdata   = acc_reg;
        lv_we      = 1'b0;

        s_tready = (state_reg == S_IDLE);

        if (cfg_we) begin
            case (cfg_addr)
                CFG_ENTRY: entry_next = cfg_wdata[5:0];
                CFG_NBLK:  nblk_next  = cfg_wdata;
                default:   entry_next = entry_reg;
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    case (s_tuser)
                        REQ_EDGE: begin
                            succ_raddr = in_src[BW-1:0];
                            src_next   = in_src[BW-1:0];
                            dst_next   = in_dst[BW-1:0];
                        end
                        REQ_LOAD: begin
                            if ({1'b0, in_bid} < n_c) begin
                                ud_we = 1'b1;
                                udv_next[in_bid[BW-1:0]] = 1'b1;
                            end
                        end
                        REQ_RUN: begin
                            reach_next = '0;
                            if ({1'b0, entry_reg} < n_c) begin
                                reach_next[entry_reg[BW-1:0]] = 1'b1;
                            end
                            pend_next = reach_next;
                        end
                        default: src_next = src_reg;
                    endcase
                end
            end
            S_EDGE_WR: begin
                succ_we    = 1'b1;
                succ_wdata = succ_q;
                succ_wdata[dst_reg] = 1'b1;
                sv_next[src_reg] = 1'b1;
            end
            S_RPICK: begin
                if (pfound_c) begin
                    pend_next[pj_c] = 1'b0;
                    succ_raddr = pj_c;
                end else begin
                    // start liveness from empty sets at the highest block
                    blk_next = nm1_c[BW-1:0];
                    chg_next = 1'b0;
                    lv_next  = '0;
                end
            end
            S_RUPD: begin
                reach_next = reach_reg | fresh_c;
                pend_next  = pend_reg | fresh_c;
            end
            S_LLAT: begin
                row_next   = succ_q & lim_c;
                use_next   = ud_q[VW-1:0];
                def_next   = ud_q[2*VW-1:VW];
                oin_next   = li_q;
                oout_next  = lo_q;
                acc_next   = '0;
                rpend_next = 1'b0;
            end
            S_LSCAN: begin
                acc_next = rpend_reg ? (acc_reg | li_q) : acc_reg;
                if (rfound_c) begin
                    li_raddr      = rj_c;
                    row_next[rj_c] = 1'b0;
                    rpend_next    = 1'b1;
                end else begin
                    rpend_next = 1'b0;
                end
            end
            S_LUPD: begin
                lv_we = 1'b1;
                lv_next[blk_reg] = 1'b1;
                chg_next = chg_reg || nin_c != oin_reg || acc_reg != oout_reg;
                if (blk_reg != '0) begin
                    blk_next = blk_reg - 1'b1;
                end else if (chg_next) begin
                    blk_next = nm1_c[BW-1:0];
                    chg_next = 1'b0;
                end
            end
            S_OLAT: begin
                ob_next     = 6'(blk_reg);
                oreach_next = reach_reg[blk_reg];
                oli_next    = li_q;
                olo_next    = lo_q;
                olast_next  = (blk_inc_c == n_c);
            end
            S_OVAL: begin
                if (m_tready && !olast_reg) begin
                    blk_next = blk_reg + 1'b1;
                end
            end
            default: blk_next = blk_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            entry_reg <= '0;
            nblk_reg  <= 7'd1;
            reach_reg <= '0;
            pend_reg  <= '0;
            sv_reg    <= '0;
            udv_reg   <= '0;
            lv_reg    <= '0;
            chg_reg   <= 1'b0;
            rpend_reg <= 1'b0;
            blk_reg   <= '0;
        end else begin
            state_reg <= state_next;
            entry_reg <= entry_next;
            nblk_reg  <= nblk_next;
            reach_reg <= reach_next;
            pend_reg  <= pend_next;
            sv_reg    <= sv_next;
            udv_reg   <= udv_next;
            lv_reg    <= lv_next;
            chg_reg   <= chg_next;
            rpend_reg <= rpend_next;
            blk_reg   <= blk_next;
        end
    end

    always_ff @(posedge aclk) begin
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        row_reg    <= row_next;
        use_reg    <= use_next;
        def_reg    <= def_next;
        oin_reg    <= oin_next;
        oout_reg   <= oout_next;
        acc_reg    <= acc_next;
        ob_reg     <= ob_next;
        oreach_reg <= oreach_next;
        olast_reg  <= olast_next;
        oli_reg    <= oli_next;
        olo_reg    <= olo_next;
    end

    always_comb begin
        li_ext = '0;
        lo_ext = '0;
        li_ext[VW-1:0] = oli_reg;
        lo_ext[VW-1:0] = olo_reg;
    end

    assign m_tvalid = (state_reg == S_OVAL);
    assign m_tlast  = olast_reg;
    assign m_tdata  = {1'b0, lo_ext[31:0], li_ext[31:0], oreach_reg, ob_reg};

`include "cfg_reachability_liveness_assert.svh"

    `CFGRL_ASSERT_NOW(a_no_overlap, m_tvalid, !s_tready, "request taken while a result is pending")
    `CFGRL_ASSERT_NOW(a_pend_in_reach, 1'b1, (pend_reg & ~reach_reg) == '0, "worklist outside reach set")
    `CFGRL_ASSERT_NEXT(a_last_idle, m_tvalid && m_tready && m_tlast, state_reg == S_IDLE, "no idle after last word")
    `CFGRL_ASSERT_NOW(a_reach_lim, state_reg == S_OVAL, (reach_reg & ~lim_c) == '0, "reach beyond block count")

endmodule
